[src/cpjr_pkg.sv]
`timescale 1ns / 1ps
package cpjr_pkg;

    localparam int VALUE_WIDTH = 24;

    localparam int IN_W       = 24;
    localparam int SUM_W      = 32;
    localparam int TQ_W       = 32;
    localparam int COEF_W     = 24;
    localparam int DT_FRAC    = 24;
    localparam int GAIN_FRAC  = 8;
    localparam int DIGIT_W    = 4;
    localparam int MUL_STEPS  = COEF_W / DIGIT_W;
    localparam int CNT_W      = $clog2(MUL_STEPS);

    localparam int ERR_W  = ((VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W) + 1;
    localparam int OPA_W  = (ERR_W > SUM_W) ? ERR_W : SUM_W;
    localparam int PROD_W = OPA_W + COEF_W;
    localparam int WIDE_W = PROD_W + 2;

    localparam int DT_HALF   = 1 << (DT_FRAC - 1);
    localparam int GAIN_HALF = 1 << (GAIN_FRAC - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int POS_KP_RST    = 6827;
    localparam int POS_KI_RST    = 11378;
    localparam int SPD_KP_RST    = 115200;
    localparam int SPD_KI_RST    = 2560000;
    localparam int DT_RST        = 16777;
    localparam int SETPOINT_RST  = 13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_KP      = 3'd0,
        REG_POS_KI      = 3'd1,
        REG_SPD_KP      = 3'd2,
        REG_SPD_KI      = 3'd3,
        REG_TIME_STEP   = 3'd4,
        REG_RAMP_EN     = 3'd5,
        REG_PLOOP_EN    = 3'd6,
        REG_INIT_TARGET = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_POST = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        OP_RAMP = 3'd0,
        OP_PSUM = 3'd1,
        OP_PKP  = 3'd2,
        OP_PKI  = 3'd3,
        OP_SSUM = 3'd4,
        OP_SKP  = 3'd5,
        OP_SKI  = 3'd6
    } t_op;

    function automatic logic signed [WIDE_W-1:0] sat_val(
        input logic signed [WIDE_W-1:0] x,
        input int n
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = '1;
        hi = hi >> (WIDE_W - n + 1);
        lo = ~hi;
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    function automatic logic sat_hit(
        input logic signed [WIDE_W-1:0] x,
        input int n
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = '1;
        hi = hi >> (WIDE_W - n + 1);
        lo = ~hi;
        return (x > hi) || (x < lo);
    endfunction

endpackage

[src/cpjr_if.sv]
`timescale 1ns / 1ps
interface cpjr_item_if import cpjr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] velocity_command;
    logic signed [IN_W-1:0] measured_position;
    logic signed [IN_W-1:0] measured_speed;

    modport source (
        output valid, velocity_command, measured_position, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, velocity_command, measured_position, measured_speed,
        output ready
    );
endinterface

interface cpjr_result_if import cpjr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [TQ_W-1:0] torque;
    logic                   saturated;

    modport source (output valid, torque, saturated, input ready);
    modport sink (input valid, torque, saturated, output ready);
endinterface

interface cpjr_cfg_if import cpjr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/cascaded_pi_joint_regulator_top.sv]
`timescale 1ns / 1ps
// Cascaded PI joint regulator. Each transaction on i_item is one control tick: an optional
// ramp integrates the velocity command into the position target, an optional outer PI stage
// turns position error into a speed setpoint, and the inner PI stage turns speed error into
// the torque returned on o_result, with saturated set if torque or an integrator clipped.
// All products run on one shared radix-16 serial multiplier (24-bit coefficient, 4 bits per
// cycle); each product is a load, six digit steps and an update, and a tick runs seven
// products with ramp and position loop on, six with only the position loop, three with both off.
// The next transaction is taken once the result is in the output register; a result waiting
// there does not hold off the next tick's work. Configuration writes are taken every cycle;
// writing initial_position_target also reloads the position target.
module cascaded_pi_joint_regulator_top import cpjr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpjr_item_if.sink    i_item,
    cpjr_result_if.source o_result,
    cpjr_cfg_if.sink     i_cfg
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [COEF_W-1:0] r_pos_kp, r_pos_ki, r_spd_kp, r_spd_ki, r_dt;
    logic              r_ramp_en, r_ploop_en;

    logic signed [VALUE_WIDTH-1:0] r_target, r_setpoint;
    logic signed [SUM_W-1:0]       r_psum, r_ssum;

    logic signed [IN_W-1:0]  r_cmd, r_pos, r_spd;
    logic signed [ERR_W-1:0] r_err;
    logic signed [OPA_W-1:0] r_ma, r_mhi;
    logic [COEF_W-1:0]       r_mlo;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [PROD_W-1:0] r_pacc;
    logic signed [TQ_W-1:0]  r_tq;
    logic                    r_sat;

    logic                    r_ovalid;
    logic signed [TQ_W-1:0]  r_otorque;
    logic                    r_osat;

    logic                             in_acc;
    logic                             cfg_acc;
    logic                             mul_last;
    logic                             out_free;
    logic signed [ERR_W-1:0]          err_new;
    logic signed [OPA_W-1:0]          opa;
    logic [COEF_W-1:0]                opb;
    logic signed [OPA_W+DIGIT_W-1:0]  step_sum;
    logic signed [PROD_W-1:0]         prod;
    logic signed [PROD_W:0]           prod_r;
    logic signed [PROD_W-DT_FRAC:0]   rnd_dt;
    logic signed [WIDE_W-1:0]         gsum;
    logic signed [WIDE_W-GAIN_FRAC-1:0] gsum_sh;
    logic signed [WIDE_W-1:0]         upd_x;
    logic signed [WIDE_W-1:0]         upd_clip;
    logic                             upd_hit;
    int                               upd_n;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_item.valid && i_item.ready;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;
    assign mul_last     = (r_cnt == CNT_W'(MUL_STEPS - 1));
    assign out_free     = !r_ovalid || o_result.ready;

    assign o_result.valid     = r_ovalid;
    assign o_result.torque    = r_otorque;
    assign o_result.saturated = r_osat;

    always_comb begin
        if (r_op == OP_PSUM) begin
            err_new = ERR_W'(r_target) - ERR_W'(r_pos);
        end else begin
            err_new = ERR_W'(r_setpoint) - ERR_W'(r_spd);
        end
    end

    always_comb begin
        case (r_op)
            OP_RAMP: begin
                opa = OPA_W'(r_cmd);
                opb = r_dt;
            end
            OP_PSUM, OP_SSUM: begin
                opa = OPA_W'(err_new);
                opb = r_dt;
            end
            OP_PKP: begin
                opa = OPA_W'(r_err);
                opb = r_pos_kp;
            end
            OP_PKI: begin
                opa = OPA_W'(r_psum);
                opb = r_pos_ki;
            end
            OP_SKP: begin
                opa = OPA_W'(r_err);
                opb = r_spd_kp;
            end
            OP_SKI: begin
                opa = OPA_W'(r_ssum);
                opb = r_spd_ki;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign step_sum = (OPA_W+DIGIT_W)'(r_mhi)
                    + r_ma * $signed({1'b0, r_mlo[DIGIT_W-1:0]});

    assign prod    = $signed({r_mhi, r_mlo});
    assign prod_r  = (PROD_W+1)'(prod) + (PROD_W+1)'(DT_HALF);
    assign rnd_dt  = $signed(prod_r[PROD_W:DT_FRAC]);
    assign gsum    = WIDE_W'(r_pacc) + WIDE_W'(prod) + WIDE_W'(GAIN_HALF);
    assign gsum_sh = $signed(gsum[WIDE_W-1:GAIN_FRAC]);

    always_comb begin
        case (r_op)
            OP_RAMP: begin
                upd_x = WIDE_W'(r_target) + WIDE_W'(rnd_dt);
                upd_n = VALUE_WIDTH;
            end
            OP_PSUM: begin
                upd_x = WIDE_W'(r_psum) + WIDE_W'(rnd_dt);
                upd_n = SUM_W;
            end
            OP_SSUM: begin
                upd_x = WIDE_W'(r_ssum) + WIDE_W'(rnd_dt);
                upd_n = SUM_W;
            end
            OP_PKI: begin
                upd_x = WIDE_W'(gsum_sh);
                upd_n = VALUE_WIDTH;
            end
            OP_SKI: begin
                upd_x = WIDE_W'(gsum_sh);
                upd_n = TQ_W;
            end
            default: begin
                upd_x = '0;
                upd_n = SUM_W;
            end
        endcase
        upd_clip = sat_val(upd_x, upd_n);
        upd_hit  = sat_hit(upd_x, upd_n) && (r_op != OP_PKI);
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                    if (r_ramp_en) begin
                        n_op = OP_RAMP;
                    end else if (r_ploop_en) begin
                        n_op = OP_PSUM;
                    end else begin
                        n_op = OP_SSUM;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_last) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_state = S_LOAD;
                case (r_op)
                    OP_RAMP: n_op = r_ploop_en ? OP_PSUM : OP_SSUM;
                    OP_PSUM: n_op = OP_PKP;
                    OP_PKP:  n_op = OP_PKI;
                    OP_PKI:  n_op = OP_SSUM;
                    OP_SSUM: n_op = OP_SKP;
                    OP_SKP:  n_op = OP_SKI;
                    OP_SKI:  n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RAMP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_kp   <= COEF_W'(POS_KP_RST);
            r_pos_ki   <= COEF_W'(POS_KI_RST);
            r_spd_kp   <= COEF_W'(SPD_KP_RST);
            r_spd_ki   <= COEF_W'(SPD_KI_RST);
            r_dt       <= COEF_W'(DT_RST);
            r_ramp_en  <= 1'b1;
            r_ploop_en <= 1'b1;
            r_target   <= '0;
            r_setpoint <= VALUE_WIDTH'(SETPOINT_RST);
            r_psum     <= '0;
            r_ssum     <= '0;
        end else begin
            if (cfg_acc) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_POS_KP:    r_pos_kp   <= i_cfg.data[COEF_W-1:0];
                    REG_POS_KI:    r_pos_ki   <= i_cfg.data[COEF_W-1:0];
                    REG_SPD_KP:    r_spd_kp   <= i_cfg.data[COEF_W-1:0];
                    REG_SPD_KI:    r_spd_ki   <= i_cfg.data[COEF_W-1:0];
                    REG_TIME_STEP: r_dt       <= i_cfg.data[COEF_W-1:0];
                    REG_RAMP_EN:   r_ramp_en  <= i_cfg.data[0];
                    REG_PLOOP_EN:  r_ploop_en <= i_cfg.data[0];
                    REG_INIT_TARGET: begin
                        r_target <= VALUE_WIDTH'(
                            sat_val(WIDE_W'($signed(i_cfg.data[IN_W-1:0])), VALUE_WIDTH));
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_POST) begin
                case (r_op)
                    OP_RAMP: r_target   <= upd_clip[VALUE_WIDTH-1:0];
                    OP_PSUM: r_psum     <= upd_clip[SUM_W-1:0];
                    OP_PKI:  r_setpoint <= upd_clip[VALUE_WIDTH-1:0];
                    OP_SSUM: r_ssum     <= upd_clip[SUM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // serial multiplier and tick datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_item.velocity_command;
            r_pos <= i_item.measured_position;
            r_spd <= i_item.measured_speed;
        end
        case (r_state)
            S_LOAD: begin
                r_ma  <= opa;
                r_mhi <= '0;
                r_mlo <= opb;
                r_cnt <= '0;
                if (r_op == OP_PSUM || r_op == OP_SSUM) begin
                    r_err <= err_new;
                end
            end
            S_MUL: begin
                r_mhi <= step_sum[OPA_W+DIGIT_W-1:DIGIT_W];
                r_mlo <= {step_sum[DIGIT_W-1:0], r_mlo[COEF_W-1:DIGIT_W]};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_POST: begin
                if (r_op == OP_PKP || r_op == OP_SKP) begin
                    r_pacc <= prod;
                end
                if (r_op == OP_SKI) begin
                    r_tq <= upd_clip[TQ_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (in_acc) begin
            r_sat <= 1'b0;
        end else if (r_state == S_POST) begin
            r_sat <= r_sat | upd_hit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_otorque <= r_tq;
            r_osat    <= r_sat;
        end
    end

    a_accept_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOAD))
        else $error("accepted transaction did not start a multiply");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_mul_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && mul_last) |=> (r_state == S_POST))
        else $error("serial multiply overran its digit count");

    a_target_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(r_target) && $past(i_rst_n)) |->
        $past((cfg_acc && i_cfg.index == REG_INIT_TARGET)
              || (r_state == S_POST && r_op == OP_RAMP)))
        else $error("position target changed without ramp or reload");

endmodule
